// ----- rtl/srr_pkg.sv -----
// Shared types and constants for the selective-repeat receiver.
package srr_pkg;

	// Fixed field widths of the packet and result channels.
	localparam int SEQ_W     = 3;
	localparam int PAYLOAD_W = 64;
	localparam int WSIZE_W   = 3;

	// Wide enough to hold a sequence number plus the sequence space without overflow.
	localparam int SEQ_EXT_W = 10;

	// Delivery counter width and the most deliveries that follow one packet.
	localparam int CNT_W     = 3;
	localparam int MAX_DELIV = 7;

	// Register reset value and parameter defaults.
	localparam logic [WSIZE_W-1:0] WSIZE_RESET = 3'd4;
	localparam int SEQ_SPACE_DEF    = 8;
	localparam int PAYLOAD_BITS_DEF = 64;

	// Result kind codes.
	typedef enum logic {
		KIND_ACK     = 1'b0,
		KIND_DELIVER = 1'b1
	} kind_t;

endpackage

// ----- rtl/srr_pkt_if.sv -----
// Received packet channel: valid/ready handshake with checksum flag, sequence number, payload.
interface srr_pkt_if;
	logic                           valid;
	logic                           ready;
	logic                           checksum_ok;
	logic [srr_pkg::SEQ_W-1:0]      seq_num;
	logic [srr_pkg::PAYLOAD_W-1:0]  payload;

	modport source (output valid, output checksum_ok, output seq_num, output payload,
		input ready);
	modport sink (input valid, input checksum_ok, input seq_num, input payload,
		output ready);
endinterface

// ----- rtl/srr_res_if.sv -----
// Result channel: valid/ready handshake with acknowledgements and in-order deliveries.
interface srr_res_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [srr_pkg::SEQ_W-1:0]      ack_num;
	logic [srr_pkg::PAYLOAD_W-1:0]  data_out;
	logic                           last;

	modport source (output valid, output kind, output ack_num, output data_out,
		output last, input ready);
	modport sink (input valid, input kind, input ack_num, input data_out, input last,
		output ready);
endinterface

// ----- rtl/selective_repeat_receiver.sv -----
// Selective-repeat receiver: one packet in, an acknowledgement and in-order deliveries out.
// Timing: a packet transfer moves the sequencer to the acknowledge state, from which the
// acknowledgement is loaded into the result register; each delivery follows the previous
// result and waits while the result channel stalls. Flow: no new packet is taken until every
// result of the last one is in the single result register; a dropped packet gives no result.
// Reset: slot occupancy cleared, window base 0, window size 4; slot memory is not cleared.
module selective_repeat_receiver #(
	parameter int SEQ_SPACE    = srr_pkg::SEQ_SPACE_DEF,
	parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [srr_pkg::WSIZE_W-1:0] cfg_wdata,
	srr_pkt_if.sink                     pkt,
	srr_res_if.source                   res
);

	localparam int IW = $clog2(SEQ_SPACE);

	logic [srr_pkg::WSIZE_W-1:0] window_size_q;
	logic                        ram_wr_en;
	logic [IW-1:0]               ram_wr_addr;
	logic [PAYLOAD_BITS-1:0]     ram_wr_data;
	logic                        ram_rd_en;
	logic [IW-1:0]               ram_rd_addr;
	logic [PAYLOAD_BITS-1:0]     ram_rd_data;

	// Window size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= srr_pkg::WSIZE_RESET;
		end else if (cfg_we) begin
			window_size_q <= cfg_wdata;
		end
	end

	srr_ctrl #(
		.SEQ_SPACE    (SEQ_SPACE),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.window_size (window_size_q),
		.pkt         (pkt),
		.res         (res),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

	srr_slot_ram #(
		.DEPTH (SEQ_SPACE),
		.WIDTH (PAYLOAD_BITS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

endmodule

// ----- rtl/srr_slot_ram.sv -----
// Payload slot memory: one write port, one read port with registered read data.
module srr_slot_ram #(
	parameter int DEPTH = srr_pkg::SEQ_SPACE_DEF,
	parameter int WIDTH = srr_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; data holds while no new read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/srr_ctrl.sv -----
// Receive window control: slot occupancy, window base, sequencing and the result register.
module srr_ctrl #(
	parameter int SEQ_SPACE    = srr_pkg::SEQ_SPACE_DEF,
	parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF,
	localparam int IW          = $clog2(SEQ_SPACE)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [srr_pkg::WSIZE_W-1:0] window_size,
	srr_pkt_if.sink                     pkt,
	srr_res_if.source                   res,
	output logic                        ram_wr_en,
	output logic [IW-1:0]               ram_wr_addr,
	output logic [PAYLOAD_BITS-1:0]     ram_wr_data,
	output logic                        ram_rd_en,
	output logic [IW-1:0]               ram_rd_addr,
	input  logic [PAYLOAD_BITS-1:0]     ram_rd_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACK,
		ST_DELIV
	} state_t;

	localparam int EW = srr_pkg::SEQ_EXT_W;

	state_t                         state_q;
	logic [SEQ_SPACE-1:0]           full_q;
	logic [IW-1:0]                  base_q;
	logic [srr_pkg::CNT_W-1:0]      cnt_q;
	logic [srr_pkg::SEQ_W-1:0]      seq_q;
	logic                           inwin_q;

	logic                           out_valid_q;
	srr_pkg::kind_t                 kind_q;
	logic [srr_pkg::SEQ_W-1:0]      ack_q;
	logic [srr_pkg::PAYLOAD_W-1:0]  data_q;
	logic                           last_q;

	logic          pkt_xfer;
	logic [EW-1:0] seq_ext;
	logic [EW-1:0] base_ext;
	logic [EW-1:0] offset;
	logic          in_space;
	logic          in_win;
	logic [IW-1:0] seq_idx;
	logic [IW-1:0] base_nxt;
	logic          slot_free;
	logic          ack_more;
	logic          deliv_more;

	// Window membership of the arriving packet, with wrap over the sequence space.
	always_comb begin
		pkt_xfer = pkt.valid && pkt.ready;
		seq_ext  = EW'(pkt.seq_num);
		base_ext = EW'(base_q);
		in_space = seq_ext < EW'(SEQ_SPACE);
		if (seq_ext >= base_ext) begin
			offset = seq_ext - base_ext;
		end else begin
			offset = seq_ext + EW'(SEQ_SPACE) - base_ext;
		end
		in_win  = in_space && (offset < EW'(window_size));
		seq_idx = seq_ext[IW-1:0];
	end

	// Next base, result slot availability and whether more deliveries follow.
	always_comb begin
		if (base_q == IW'(SEQ_SPACE - 1)) begin
			base_nxt = '0;
		end else begin
			base_nxt = base_q + IW'(1);
		end
		slot_free  = !out_valid_q || res.ready;
		ack_more   = inwin_q && full_q[base_q];
		deliv_more = (cnt_q < srr_pkg::CNT_W'(srr_pkg::MAX_DELIV - 1)) && full_q[base_nxt];
	end

	// Memory accesses: store on an in-window transfer with a good checksum, prefetch the next slot to deliver.
	always_comb begin
		ram_wr_en   = pkt_xfer && pkt.checksum_ok && in_win;
		ram_wr_addr = seq_idx;
		ram_wr_data = pkt.payload[PAYLOAD_BITS-1:0];
		ram_rd_en   = slot_free && (((state_q == ST_ACK) && ack_more) ||
			((state_q == ST_DELIV) && deliv_more));
		ram_rd_addr = (state_q == ST_ACK) ? base_q : base_nxt;
	end

	assign pkt.ready    = (state_q == ST_IDLE);
	assign res.valid    = out_valid_q;
	assign res.kind     = kind_q;
	assign res.ack_num  = ack_q;
	assign res.data_out = data_q;
	assign res.last     = last_q;

	// Sequencer, window state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			full_q      <= '0;
			base_q      <= '0;
			cnt_q       <= '0;
			seq_q       <= '0;
			inwin_q     <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= srr_pkg::KIND_ACK;
			ack_q       <= '0;
			data_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pkt_xfer && pkt.checksum_ok) begin
						seq_q   <= pkt.seq_num;
						inwin_q <= in_win;
						if (in_win) begin
							full_q[seq_idx] <= 1'b1;
						end
						state_q <= ST_ACK;
					end
				end
				ST_ACK: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= srr_pkg::KIND_ACK;
						ack_q       <= seq_q;
						data_q      <= '0;
						last_q      <= !ack_more;
						cnt_q       <= '0;
						state_q     <= ack_more ? ST_DELIV : ST_IDLE;
					end
				end
				ST_DELIV: begin
					if (slot_free) begin
						out_valid_q    <= 1'b1;
						kind_q         <= srr_pkg::KIND_DELIVER;
						ack_q          <= '0;
						data_q         <= srr_pkg::PAYLOAD_W'(ram_rd_data);
						last_q         <= !deliv_more;
						full_q[base_q] <= 1'b0;
						base_q         <= base_nxt;
						cnt_q          <= cnt_q + srr_pkg::CNT_W'(1);
						state_q        <= deliv_more ? ST_DELIV : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
